// ----- sv/npcc_pkg.sv -----
// Package for the nearest point collision check block.
// Holds sizes, register codes, defaults and the item, result and configuration types.
// Depends on nothing; every other file imports it.
package npcc_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int COORD_W    = 24;
    localparam int DIST_W     = 50;
    localparam int STEP_W     = 23;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PT_ADDR_W  = $clog2(MAX_POINTS);
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_COLLIDE_DIST_SQ = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FAR_DIST_SQ     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NEAR_DIST_SQ    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LONG_STEP       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MEDIUM_STEP     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_STEP      = 3'd5;

    localparam logic [DIST_W-1:0] RST_COLLIDE_DIST_SQ = DIST_W'(65536);
    localparam logic [DIST_W-1:0] RST_FAR_DIST_SQ     = DIST_W'(6553600);
    localparam logic [DIST_W-1:0] RST_NEAR_DIST_SQ    = DIST_W'(1638400);
    localparam logic [STEP_W-1:0] RST_LONG_STEP       = STEP_W'(2560);
    localparam logic [STEP_W-1:0] RST_MEDIUM_STEP     = STEP_W'(1280);
    localparam logic [STEP_W-1:0] RST_SHORT_STEP      = STEP_W'(256);

    // 1e8 in real units squared, scaled to Q34.16
    localparam logic [DIST_W-1:0] SENTINEL_SQ = DIST_W'(64'd100000000 << 16);

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_ADD   = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } item_t;

    typedef struct packed {
        logic              collided;
        logic [DIST_W-1:0] min_dist_sq;
        logic [STEP_W-1:0] step_length;
        logic [CNT_W-1:0]  stored_count;
        logic              store_full;
    } result_t;

    typedef struct packed {
        logic [DIST_W-1:0] collide_dist_sq;
        logic [DIST_W-1:0] far_dist_sq;
        logic [DIST_W-1:0] near_dist_sq;
        logic [STEP_W-1:0] long_step;
        logic [STEP_W-1:0] medium_step;
        logic [STEP_W-1:0] short_step;
    } cfg_t;

endpackage

// ----- sv/npcc_cfg.sv -----
// APB register file for the collision check thresholds and step lengths.
// Depends on npcc_pkg for register codes, reset values and cfg_t.
module npcc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [npcc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [npcc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [npcc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output npcc_pkg::cfg_t                  cfg
);
    import npcc_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign idx    = paddr[APB_ADDR_W-1:3];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_COLLIDE_DIST_SQ: cfg_next.collide_dist_sq = pwdata[DIST_W-1:0];
                REG_FAR_DIST_SQ:     cfg_next.far_dist_sq     = pwdata[DIST_W-1:0];
                REG_NEAR_DIST_SQ:    cfg_next.near_dist_sq    = pwdata[DIST_W-1:0];
                REG_LONG_STEP:       cfg_next.long_step       = pwdata[STEP_W-1:0];
                REG_MEDIUM_STEP:     cfg_next.medium_step     = pwdata[STEP_W-1:0];
                REG_SHORT_STEP:      cfg_next.short_step      = pwdata[STEP_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_COLLIDE_DIST_SQ: prdata = APB_DATA_W'(cfg_reg.collide_dist_sq);
            REG_FAR_DIST_SQ:     prdata = APB_DATA_W'(cfg_reg.far_dist_sq);
            REG_NEAR_DIST_SQ:    prdata = APB_DATA_W'(cfg_reg.near_dist_sq);
            REG_LONG_STEP:       prdata = APB_DATA_W'(cfg_reg.long_step);
            REG_MEDIUM_STEP:     prdata = APB_DATA_W'(cfg_reg.medium_step);
            REG_SHORT_STEP:      prdata = APB_DATA_W'(cfg_reg.short_step);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.collide_dist_sq <= RST_COLLIDE_DIST_SQ;
            cfg_reg.far_dist_sq     <= RST_FAR_DIST_SQ;
            cfg_reg.near_dist_sq    <= RST_NEAR_DIST_SQ;
            cfg_reg.long_step       <= RST_LONG_STEP;
            cfg_reg.medium_step     <= RST_MEDIUM_STEP;
            cfg_reg.short_step      <= RST_SHORT_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/npcc_store.sv -----
// Point store: one write port, one registered read port for x and y.
// Entry 0 is the origin and reads as zero without ever being written.
// Depends on npcc_pkg for widths.
module npcc_store (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [npcc_pkg::PT_ADDR_W-1:0]        wr_addr,
    input  logic signed [npcc_pkg::COORD_W-1:0]   wr_x,
    input  logic signed [npcc_pkg::COORD_W-1:0]   wr_y,
    input  logic [npcc_pkg::PT_ADDR_W-1:0]        rd_addr,
    output logic signed [npcc_pkg::COORD_W-1:0]   rd_x,
    output logic signed [npcc_pkg::COORD_W-1:0]   rd_y
);
    import npcc_pkg::*;

    logic [COORD_W-1:0] mem_x [MAX_POINTS];
    logic [COORD_W-1:0] mem_y [MAX_POINTS];
    logic [COORD_W-1:0] q_x_reg;
    logic [COORD_W-1:0] q_y_reg;
    logic               origin_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        q_x_reg    <= mem_x[rd_addr];
        q_y_reg    <= mem_y[rd_addr];
        origin_reg <= (rd_addr == '0);
    end

    assign rd_x = origin_reg ? '0 : $signed(q_x_reg);
    assign rd_y = origin_reg ? '0 : $signed(q_y_reg);

endmodule

// ----- sv/npcc_dist.sv -----
// Pipelined squared-distance unit shared by every point of a scan.
// Stages: store read, absolute difference, square, sum. Flush drops all in flight.
// Depends on npcc_pkg for widths.
module npcc_dist (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req,
    input  logic                                flush,
    input  logic signed [npcc_pkg::COORD_W-1:0] walker_x,
    input  logic signed [npcc_pkg::COORD_W-1:0] walker_y,
    input  logic signed [npcc_pkg::COORD_W-1:0] pt_x,
    input  logic signed [npcc_pkg::COORD_W-1:0] pt_y,
    output logic                                res_valid,
    output logic [npcc_pkg::DIST_W-1:0]         res_dist
);
    import npcc_pkg::*;

    logic               v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [DIFF_W-1:0]  adx_reg, ady_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic [SQ_W-1:0]    sum_reg;

    assign dx = DIFF_W'(walker_x) - DIFF_W'(pt_x);
    assign dy = DIFF_W'(walker_y) - DIFF_W'(pt_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= req & ~flush;
            v1_reg <= v0_reg & ~flush;
            v2_reg <= v1_reg & ~flush;
            v3_reg <= v2_reg & ~flush;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ady_reg <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        sqx_reg <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
        sqy_reg <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
        sum_reg <= sqx_reg + sqy_reg;
    end

    assign res_valid = v3_reg;
    assign res_dist  = DIST_W'(sum_reg);

endmodule

// ----- sv/nearest_point_collision_check.sv -----
// Nearest point collision check: top level with the scan sequencer and result register.
// Depends on npcc_pkg, npcc_cfg, npcc_store and npcc_dist.
//
//   channel  | handshake                 | payload
//   item     | item_valid / item_stall   | item   (npcc_pkg::item_t)
//   result   | result_valid/result_stall | result (npcc_pkg::result_t)
//   config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// An add item goes straight to the finish state for its result; a query first scans the store,
// ending early on a collision. The scan reads one point a cycle from the single store port.
// Reset leaves one point, the origin, in the store; no clearing pass is needed.
// item_stall is high from acceptance until the result is loaded into the result register.
// A stalled result holds while the next item is already taken.
module nearest_point_collision_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  npcc_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output npcc_pkg::result_t               result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [npcc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [npcc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [npcc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import npcc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    cfg_t               cfg;
    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic [CNT_W-1:0]   rcv_reg, rcv_next;
    logic               kind_reg, full_reg, collided_reg;
    logic [DIST_W-1:0]  min_reg;
    logic signed [COORD_W-1:0] walker_x_reg, walker_y_reg;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg;

    logic               accept, is_full, wr_en, issue, hit, load_out;
    logic               d_valid;
    logic [DIST_W-1:0]  d_dist;
    logic signed [COORD_W-1:0] pt_x, pt_y;
    logic [STEP_W-1:0]  step;

    npcc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    npcc_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[PT_ADDR_W-1:0]),
        .wr_x    (item.x_coord),
        .wr_y    (item.y_coord),
        .rd_addr (issue_reg[PT_ADDR_W-1:0]),
        .rd_x    (pt_x),
        .rd_y    (pt_y)
    );

    npcc_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (issue),
        .flush     (hit),
        .walker_x  (walker_x_reg),
        .walker_y  (walker_y_reg),
        .pt_x      (pt_x),
        .pt_y      (pt_y),
        .res_valid (d_valid),
        .res_dist  (d_dist)
    );

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid & ~item_stall;
    assign is_full    = (count_reg == CNT_W'(MAX_POINTS));
    assign wr_en      = accept & (item.kind == KIND_ADD) & ~is_full;
    assign hit        = (state_reg == ST_SCAN) & d_valid & (d_dist <= cfg.collide_dist_sq);
    assign issue      = (state_reg == ST_SCAN) & (issue_reg < count_reg) & ~hit;
    assign load_out   = (state_reg == ST_FINISH) & (~result_valid_reg | ~result_stall);

    always_comb
    begin
        priority if (kind_reg == KIND_ADD || collided_reg)
            step = '0;
        else if (min_reg >= cfg.far_dist_sq)
            step = cfg.long_step;
        else if (min_reg < cfg.near_dist_sq)
            step = cfg.short_step;
        else
            step = cfg.medium_step;
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        issue_next        = issue_reg;
        rcv_next          = rcv_reg;
        result_valid_next = result_valid_reg & result_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    issue_next = '0;
                    rcv_next   = '0;
                    if (wr_en)
                        count_next = count_reg + CNT_W'(1);
                    state_next = (item.kind == KIND_ADD) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                    issue_next = issue_reg + CNT_W'(1);
                if (d_valid)
                begin
                    rcv_next = rcv_reg + CNT_W'(1);
                    if (hit || (rcv_reg + CNT_W'(1) == count_reg))
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= CNT_W'(1);
            issue_reg        <= '0;
            rcv_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            issue_reg        <= issue_next;
            rcv_reg          <= rcv_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= item.kind;
            full_reg     <= (item.kind == KIND_ADD) & is_full;
            collided_reg <= 1'b0;
            min_reg      <= (item.kind == KIND_ADD) ? '0 : SENTINEL_SQ;
            walker_x_reg <= item.x_coord;
            walker_y_reg <= item.y_coord;
        end
        else if (state_reg == ST_SCAN && d_valid)
        begin
            if (d_dist < min_reg)
                min_reg <= d_dist;
            if (hit)
                collided_reg <= 1'b1;
        end
        if (load_out)
        begin
            result_reg.collided     <= collided_reg;
            result_reg.min_dist_sq  <= min_reg;
            result_reg.step_length  <= step;
            result_reg.stored_count <= count_reg;
            result_reg.store_full   <= full_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count out of range");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.kind == KIND_ADD && !is_full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("add did not grow the store");

    a_rcv_behind_issue: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> rcv_reg <= issue_reg && issue_reg <= count_reg)
        else $error("scan counters out of order");

    a_collide_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.collided |-> result.step_length == '0 && !result.store_full)
        else $error("collision with nonzero step");

    a_min_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> result.min_dist_sq <= SENTINEL_SQ)
        else $error("least distance above sentinel");

endmodule
